// ===== rtl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Shared sizes, status codes and the insert bus that is broadcast to the cells.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int DEPTH  = 16;                  // table entries
    localparam int DATA_W = 32;                  // entry width
    localparam int IDX_W  = $clog2(DEPTH);       // index into the table
    localparam int CNT_W  = $clog2(DEPTH + 1);   // fill count, holds DEPTH itself
    localparam int POS_W  = 4;                   // reported position field
    localparam int STAT_W = 2;                   // status field

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_APPENDED  = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Insert command seen by every cell in the same cycle
    typedef struct packed {
        logic                     en;
        logic signed [DATA_W-1:0] value;
    } t_ins;

endpackage

// ===== rtl/stbs_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one table entry. On an insert, an entry larger than the new value
// moves one place up the row: the cell takes its left neighbor's entry, or
// the new value when the neighbor stays put.
// ----------------------------------------------------------------------------
module stbs_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  stbs_pkg::t_ins                   i_ins,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_left_entry,
    input  logic                             i_left_valid,
    input  logic                             i_left_move,
    output logic signed [stbs_pkg::DATA_W-1:0] o_entry,
    output logic                             o_valid,
    output logic                             o_move
);
    import stbs_pkg::*;

    logic signed [DATA_W-1:0] r_entry;
    logic                     r_valid;

    // Cell must change when it is empty or holds a value above the new one
    assign o_move  = !r_valid || ($signed(r_entry) > $signed(i_ins.value));
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    // Shift up or take the new value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ins.en && o_move) begin
            if (!i_left_move) begin
                r_entry <= i_ins.value;
                r_valid <= 1'b1;
            end else begin
                r_entry <= i_left_entry;
                r_valid <= i_left_valid;
            end
        end
    end

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search
// Table of signed values kept in ascending order by a row of insert cells,
// searched by a one-probe-per-cycle binary search.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An append item is
// placed into sorted position in the cycle it is accepted and its result
// appears on the next cycle; the block is ready again at once. A search
// item holds busy while the binary search probes the table, with a single
// compare on the probed entry per probe, until the key is found or, when
// the key is absent, until the range is seen to be empty. Each result is
// shown for exactly one cycle with o_done high and must be captured then:
// the block cannot be stalled by the receiver. A full table drops appended
// values.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_mode,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_value,
    output logic                               o_done,
    output logic        [stbs_pkg::STAT_W-1:0] o_status,
    output logic        [stbs_pkg::POS_W-1:0]  o_position
);
    import stbs_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_lo;
    logic [CNT_W-1:0]         r_hip1;     // upper bound plus one
    logic signed [DATA_W-1:0] r_key;
    logic                     r_done;
    t_status                  r_status;
    logic [POS_W-1:0]         r_pos;

    t_ins                     w_ins;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_range_empty;
    logic [CNT_W:0]           w_sum;
    logic [CNT_W-1:0]         w_mid;
    logic signed [DATA_W-1:0] w_probe;

    logic signed [DATA_W-1:0] w_entry [DEPTH];
    logic                     w_valid [DEPTH];
    logic                     w_move  [DEPTH];

    // Handshake and insert command
    assign busy     = (r_state == S_PROBE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(DEPTH));

    assign w_ins.en    = w_accept && (i_mode == MODE_APPEND) && !w_full;
    assign w_ins.value = i_value;

    // Row of cells, cell 0 at the low end of the table
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            stbs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ins        (w_ins),
                .i_left_entry ('0),
                .i_left_valid (1'b0),
                .i_left_move  (1'b0),
                .o_entry      (w_entry[g]),
                .o_valid      (w_valid[g]),
                .o_move       (w_move[g])
            );
        end else begin : g_rest
            stbs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ins        (w_ins),
                .i_left_entry (w_entry[g-1]),
                .i_left_valid (w_valid[g-1]),
                .i_left_move  (w_move[g-1]),
                .o_entry      (w_entry[g]),
                .o_valid      (w_valid[g]),
                .o_move       (w_move[g])
            );
        end
    end

    // Midpoint floor((lo+hi)/2) with hi = hip1 - 1, and the probed entry
    assign w_range_empty = (r_lo >= r_hip1);
    assign w_sum   = {1'b0, r_lo} + {1'b0, r_hip1} - (CNT_W+1)'(1);
    assign w_mid   = w_sum[CNT_W:1];
    assign w_probe = w_entry[w_mid[IDX_W-1:0]];

    // Control, search bounds and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_mode == MODE_APPEND) begin
                            r_done <= 1'b1;
                            r_pos  <= '0;
                            if (w_full) begin
                                r_status <= ST_DROPPED;
                            end else begin
                                r_status <= ST_APPENDED;
                                r_count  <= r_count + CNT_W'(1);
                            end
                        end else begin
                            r_lo    <= '0;
                            r_hip1  <= r_count;
                            r_key   <= i_value;
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    if (w_range_empty) begin
                        r_done   <= 1'b1;
                        r_status <= ST_NOT_FOUND;
                        r_pos    <= '0;
                        r_state  <= S_IDLE;
                    end else if (w_probe == r_key) begin
                        r_done   <= 1'b1;
                        r_status <= ST_FOUND;
                        r_pos    <= POS_W'(w_mid);
                        r_state  <= S_IDLE;
                    end else if ($signed(r_key) < $signed(w_probe)) begin
                        r_hip1 <= w_mid;
                    end else begin
                        r_lo <= w_mid + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_position = r_pos;

endmodule
